### design/iuge_pkg.sv
// Shared types, widths and codes for the interval union and gap engine.
package iuge_pkg;

    // Capacity of the interval list.
    localparam int LIST_DEPTH = 32;
    // The gap buffer can hold one more entry than the list.
    localparam int GAP_DEPTH  = LIST_DEPTH + 1;
    localparam int LADDR_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LCNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int GADDR_W    = $clog2(GAP_DEPTH);
    localparam int GCNT_W     = $clog2(GAP_DEPTH + 1);
    localparam int TIME_W     = 32;
    localparam int OCNT_W     = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MERGE  = 2'd1,
        CMD_GAPS   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        t_command            command;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   stop_time;
    } t_request;

    typedef struct packed {
        t_kind               kind;
        logic                status;
        logic [TIME_W-1:0]   out_start;
        logic [TIME_W-1:0]   out_stop;
        logic [TIME_W-1:0]   total_length;
        logic [OCNT_W-1:0]   entry_count;
        logic                last;
    } t_result;

    // One stored interval or gap.
    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   stop;
    } t_pair;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_ACK       = 4'd2,
        OP_INS_RD    = 4'd3,
        OP_INS_CMP   = 4'd4,
        OP_INS_PUT0  = 4'd5,
        OP_LD        = 4'd6,
        OP_MRG_CUR   = 4'd7,
        OP_MRG_STEP  = 4'd8,
        OP_MRG_FLUSH = 4'd9,
        OP_GAP_CHK   = 4'd10,
        OP_GAP_GEN   = 4'd11,
        OP_EMIT      = 4'd12,
        OP_SUM       = 4'd13
    } t_op;

    typedef struct packed {
        t_op   op;
        logic  tgt_gap;     // insertion works on the gap buffer, not the list
    } t_dp_cmd;

    typedef struct packed {
        logic  count_zero;
        logic  count_full;
        logic  gcount_zero;
        logic  less;        // new pair sorts strictly before the pair read
        logic  j_zero;
        logic  cur_lt_stop;
        logic  i_lt_count;
        logic  i_last_list;
        logic  i_last_gap;
    } t_status;

endpackage

### design/interval_union_and_gap_engine.sv
// Top level of the interval union and gap engine: controller plus datapath.
//
// The engine keeps up to LIST_DEPTH intervals sorted by start, then stop, and
// takes one request at a time: a request is accepted on a clock edge where
// start is high and busy is low, and busy then stays high until the request's
// last result has been issued. Results come one per cycle at most on o_res,
// each marked by o_valid for exactly one cycle, and they cannot be held off,
// so the receiver must take every result in the cycle it appears. The final
// result of each request carries last. Timing is set by the single read port
// of the list memory and of the gap sort buffer, both of which are walked one
// entry per cycle. An insert walks down past the entries that sort after the
// new one; a clear, or an insert into a full list, goes straight to its
// acknowledgement. A merge walks the whole list (an empty list goes straight to
// the summary) and issues its results as it goes. A gap query sorts each gap
// into the gap buffer as it is produced, walking past the gaps that sort after
// it (an ordered list needs no reordering), and then issues the gaps and the
// summary. The list needs no clearing after reset: only the fill count is
// reset, and entries at or above it are never read.
module interval_union_and_gap_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  iuge_pkg::t_request i_req,
    output logic               busy,
    output logic               o_valid,
    output iuge_pkg::t_result  o_res
);
    import iuge_pkg::*;

    t_dp_cmd dp_cmd;
    t_status dp_status;

    // Sequencing: one state per step of insert, merge, gap search and issue.
    iuge_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_req.command),
        .i_status  (dp_status),
        .o_busy    (busy),
        .o_cmd     (dp_cmd)
    );

    // Storage, comparators, running totals and the registered result port.
    iuge_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

endmodule

### design/iuge_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module iuge_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/iuge_ctrl.sv
// Controller state machine that sequences the interval engine datapath.
module iuge_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  iuge_pkg::t_command i_command,
    input  iuge_pkg::t_status  i_status,
    output logic               o_busy,
    output iuge_pkg::t_dp_cmd  o_cmd
);
    import iuge_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_ACK       = 14'b00000000000010,
        S_INS_RD    = 14'b00000000000100,
        S_INS_CMP   = 14'b00000000001000,
        S_INS_PUT0  = 14'b00000000010000,
        S_MRG_LD    = 14'b00000000100000,
        S_MRG_CUR   = 14'b00000001000000,
        S_MRG_STEP  = 14'b00000010000000,
        S_MRG_FLUSH = 14'b00000100000000,
        S_GAP_CHK   = 14'b00001000000000,
        S_GAP_GEN   = 14'b00010000000000,
        S_EMIT_LD   = 14'b00100000000000,
        S_EMIT      = 14'b01000000000000,
        S_SUM       = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_tgt_gap, n_tgt_gap;
    logic   r_tail, n_tail;
    t_state ins_done;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Where to go once an insertion has placed its pair.
    always_comb begin
        if (!r_tgt_gap) begin
            ins_done = S_ACK;
        end else if (r_tail) begin
            ins_done = S_EMIT_LD;
        end else begin
            ins_done = S_GAP_CHK;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_tgt_gap = r_tgt_gap;
        n_tail    = r_tail;
        o_cmd     = '{op: OP_NONE, tgt_gap: r_tgt_gap};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = OP_ACCEPT;
                    unique case (i_command)
                        CMD_INSERT: begin
                            n_tgt_gap = 1'b0;
                            if (i_status.count_full) begin
                                n_state = S_ACK;
                            end else if (i_status.count_zero) begin
                                n_state = S_INS_PUT0;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_MERGE: begin
                            n_state = i_status.count_zero ? S_SUM : S_MRG_LD;
                        end
                        CMD_GAPS: begin
                            n_state = S_GAP_CHK;
                        end
                        CMD_CLEAR: begin
                            n_state = S_ACK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK: begin
                o_cmd.op = OP_ACK;
                n_state  = S_IDLE;
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = S_INS_CMP;
            end
            S_INS_CMP: begin
                o_cmd.op = OP_INS_CMP;
                if (!i_status.less) begin
                    n_state = ins_done;
                end else if (i_status.j_zero) begin
                    n_state = S_INS_PUT0;
                end
            end
            S_INS_PUT0: begin
                o_cmd.op = OP_INS_PUT0;
                n_state  = ins_done;
            end
            S_MRG_LD: begin
                o_cmd.op = OP_LD;
                n_state  = S_MRG_CUR;
            end
            S_MRG_CUR: begin
                o_cmd.op = OP_MRG_CUR;
                n_state  = i_status.i_last_list ? S_MRG_FLUSH : S_MRG_STEP;
            end
            S_MRG_STEP: begin
                o_cmd.op = OP_MRG_STEP;
                if (i_status.i_last_list) begin
                    n_state = S_MRG_FLUSH;
                end
            end
            S_MRG_FLUSH: begin
                o_cmd.op = OP_MRG_FLUSH;
                n_state  = S_SUM;
            end
            S_GAP_CHK: begin
                o_cmd.op = OP_GAP_CHK;
                priority if (i_status.cur_lt_stop && i_status.i_lt_count) begin
                    n_state = S_GAP_GEN;
                end else if (i_status.cur_lt_stop) begin
                    n_tgt_gap = 1'b1;
                    n_tail    = 1'b1;
                    n_state   = i_status.gcount_zero ? S_INS_PUT0 : S_INS_RD;
                end else begin
                    n_state = i_status.gcount_zero ? S_SUM : S_EMIT_LD;
                end
            end
            S_GAP_GEN: begin
                o_cmd.op  = OP_GAP_GEN;
                n_tgt_gap = 1'b1;
                n_tail    = 1'b0;
                n_state   = i_status.gcount_zero ? S_INS_PUT0 : S_INS_RD;
            end
            S_EMIT_LD: begin
                o_cmd.op = OP_LD;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (i_status.i_last_gap) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tgt_gap <= 1'b0;
            r_tail    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tgt_gap <= n_tgt_gap;
            r_tail    <= n_tail;
        end
    end

endmodule

### design/iuge_dpath.sv
// Datapath of the interval engine: list and gap memories, scan registers, result register.
module iuge_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iuge_pkg::t_request i_req,
    input  iuge_pkg::t_dp_cmd i_cmd,
    output iuge_pkg::t_status o_status,
    output logic              o_valid,
    output iuge_pkg::t_result o_res
);
    import iuge_pkg::*;

    logic [LCNT_W-1:0]  r_count, n_count, r_w, n_w;
    logic [GCNT_W-1:0]  r_gcount, n_gcount, r_i, n_i, r_j, n_j, r_pos, n_pos;
    logic [TIME_W-1:0]  r_cur, n_cur, r_win_stop, n_win_stop, r_total, n_total;
    logic [TIME_W-1:0]  r_cs, n_cs, r_ce, n_ce;
    t_pair              r_ins, n_ins;
    logic               r_full, n_full;
    logic               r_valid, n_valid;
    t_result            r_res, n_res;

    t_pair              l_rdata, g_rdata, d_ins, ins_wdata, l_wdata;
    logic               ins_op, ins_wr, mrg_wr, l_we, g_we, less, overlap, fl_nz;
    logic [GCNT_W-1:0]  ins_raddr, ins_waddr, count_ext;
    logic [LADDR_W-1:0] l_raddr, l_waddr;
    logic [GADDR_W-1:0] g_raddr, g_waddr;
    logic [TIME_W-1:0]  fl_len, g_len;

    assign count_ext = GCNT_W'(r_count);

    // Insertion walks down from the top entry, moving larger pairs up by one.
    assign ins_op    = (i_cmd.op == OP_INS_RD) || (i_cmd.op == OP_INS_CMP) ||
                       (i_cmd.op == OP_INS_PUT0);
    assign ins_wr    = (i_cmd.op == OP_INS_CMP) || (i_cmd.op == OP_INS_PUT0);
    assign ins_raddr = (i_cmd.op == OP_INS_CMP) ? r_j - 1'b1 : r_j;
    assign ins_waddr = (i_cmd.op == OP_INS_CMP) ? r_j + 1'b1 : '0;
    assign d_ins     = i_cmd.tgt_gap ? g_rdata : l_rdata;
    assign less      = (r_ins.start < d_ins.start) ||
                       ((r_ins.start == d_ins.start) && (r_ins.stop < d_ins.stop));
    assign ins_wdata = ((i_cmd.op == OP_INS_CMP) && less) ? d_ins : r_ins;

    // Merge keeps a current interval and writes it back once it closes, unless it is empty.
    assign overlap = r_ce > l_rdata.start;
    assign fl_nz   = (r_cs != r_ce);
    assign fl_len  = r_ce - r_cs;
    assign g_len   = g_rdata.stop - g_rdata.start;
    assign mrg_wr  = (((i_cmd.op == OP_MRG_STEP) && !overlap) ||
                      (i_cmd.op == OP_MRG_FLUSH)) && fl_nz;

    assign l_we    = (ins_wr && !i_cmd.tgt_gap) || mrg_wr;
    assign l_waddr = ins_wr ? ins_waddr[LADDR_W-1:0] : r_w[LADDR_W-1:0];
    assign l_wdata = ins_wr ? ins_wdata : t_pair'{start: r_cs, stop: r_ce};
    assign l_raddr = (ins_op && !i_cmd.tgt_gap) ? ins_raddr[LADDR_W-1:0] : r_i[LADDR_W-1:0];
    assign g_we    = ins_wr && i_cmd.tgt_gap;
    assign g_waddr = ins_waddr[GADDR_W-1:0];
    assign g_raddr = (ins_op && i_cmd.tgt_gap) ? ins_raddr[GADDR_W-1:0] : r_i[GADDR_W-1:0];

    iuge_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    iuge_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (GAP_DEPTH)
    ) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (ins_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    always_comb begin
        o_status.count_zero  = (r_count == '0);
        o_status.count_full  = (r_count == LCNT_W'(LIST_DEPTH));
        o_status.gcount_zero = (r_gcount == '0);
        o_status.less        = less;
        o_status.j_zero      = (r_j == '0);
        o_status.cur_lt_stop = (r_cur < r_win_stop);
        o_status.i_lt_count  = (r_i < count_ext);
        o_status.i_last_list = (r_i == count_ext);
        o_status.i_last_gap  = (r_i == r_gcount);
    end

    always_comb begin
        n_count    = r_count;
        n_w        = r_w;
        n_gcount   = r_gcount;
        n_i        = r_i;
        n_j        = r_j;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_win_stop = r_win_stop;
        n_total    = r_total;
        n_cs       = r_cs;
        n_ce       = r_ce;
        n_ins      = r_ins;
        n_full     = r_full;
        n_valid    = 1'b0;
        n_res      = r_res;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_ACCEPT: begin
                n_ins      = '{start: i_req.start_time, stop: i_req.stop_time};
                n_cur      = i_req.start_time;
                n_win_stop = i_req.stop_time;
                n_j        = count_ext - 1'b1;
                n_i        = '0;
                n_w        = '0;
                n_gcount   = '0;
                n_pos      = '0;
                n_total    = '0;
                n_full     = (i_req.command == CMD_INSERT) && o_status.count_full;
                if (i_req.command == CMD_CLEAR) begin
                    n_count = '0;
                end
            end
            OP_ACK: begin
                n_valid = 1'b1;
                n_res   = '{kind: KIND_ACK, status: r_full, out_start: '0, out_stop: '0,
                            total_length: '0, entry_count: OCNT_W'(r_count), last: 1'b1};
            end
            OP_INS_RD: begin
            end
            OP_INS_CMP: begin
                if (less) begin
                    n_j = r_j - 1'b1;
                end else if (i_cmd.tgt_gap) begin
                    n_gcount = r_gcount + 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_INS_PUT0: begin
                if (i_cmd.tgt_gap) begin
                    n_gcount = r_gcount + 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_LD: begin
                n_i = r_i + 1'b1;
            end
            OP_MRG_CUR: begin
                n_cs = l_rdata.start;
                n_ce = l_rdata.stop;
                n_i  = r_i + 1'b1;
            end
            OP_MRG_STEP: begin
                n_i = r_i + 1'b1;
                if (overlap) begin
                    if (r_ce < l_rdata.stop) begin
                        n_ce = l_rdata.stop;
                    end
                end else begin
                    n_cs = l_rdata.start;
                    n_ce = l_rdata.stop;
                    if (fl_nz) begin
                        n_w     = r_w + 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_total = r_total + fl_len;
                        n_valid = 1'b1;
                        n_res   = '{kind: KIND_ENTRY, status: 1'b0, out_start: r_cs,
                                    out_stop: r_ce, total_length: r_total + fl_len,
                                    entry_count: OCNT_W'(r_pos + 1'b1), last: 1'b0};
                    end
                end
            end
            OP_MRG_FLUSH: begin
                n_count = r_w + LCNT_W'(fl_nz);
                if (fl_nz) begin
                    n_pos   = r_pos + 1'b1;
                    n_total = r_total + fl_len;
                    n_valid = 1'b1;
                    n_res   = '{kind: KIND_ENTRY, status: 1'b0, out_start: r_cs,
                                out_stop: r_ce, total_length: r_total + fl_len,
                                entry_count: OCNT_W'(r_pos + 1'b1), last: 1'b0};
                end
            end
            OP_GAP_CHK: begin
                if (o_status.cur_lt_stop && o_status.i_lt_count) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_i = '0;
                    if (o_status.cur_lt_stop) begin
                        n_ins = '{start: r_cur, stop: r_win_stop};
                        n_j   = r_gcount - 1'b1;
                    end
                end
            end
            OP_GAP_GEN: begin
                n_ins = '{start: r_cur, stop: l_rdata.start};
                n_cur = l_rdata.stop;
                n_j   = r_gcount - 1'b1;
            end
            OP_EMIT: begin
                n_i     = r_i + 1'b1;
                n_pos   = r_pos + 1'b1;
                n_total = r_total + g_len;
                n_valid = 1'b1;
                n_res   = '{kind: KIND_ENTRY, status: 1'b0, out_start: g_rdata.start,
                            out_stop: g_rdata.stop, total_length: r_total + g_len,
                            entry_count: OCNT_W'(r_pos + 1'b1), last: 1'b0};
            end
            OP_SUM: begin
                n_valid = 1'b1;
                n_res   = '{kind: KIND_SUMMARY, status: 1'b0, out_start: '0, out_stop: '0,
                            total_length: r_total, entry_count: OCNT_W'(r_pos), last: 1'b1};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_gcount   <= n_gcount;
        r_i        <= n_i;
        r_j        <= n_j;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_win_stop <= n_win_stop;
        r_total    <= n_total;
        r_cs       <= n_cs;
        r_ce       <= n_ce;
        r_ins      <= n_ins;
        r_full     <= n_full;
        r_res      <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/iuge_checker.sv
// Port-level checks on the request and result timing of the interval engine.
module iuge_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input logic               i_valid,
    input iuge_pkg::t_result  i_res
);
    import iuge_pkg::*;

    // Every accepted request raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("engine not busy after accepting a request");

    // The final result of a request appears as the engine returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_res.last) |-> !i_busy)
        else $error("final result issued while still busy");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_res.last) |-> i_busy)
        else $error("non-final result issued while idle");

    // Going idle always coincides with the final result of the request.
    a_fell_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_busy) |-> (i_valid && i_res.last))
        else $error("engine went idle without a final result");

    a_entry_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_res.kind == KIND_ENTRY)) |-> (i_res.entry_count != '0))
        else $error("interval entry issued with position zero");

endmodule

bind interval_union_and_gap_engine iuge_assertions u_iuge_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid),
    .i_res   (o_res)
);

### bench/iuge_checker.sv
// Result checker for the interval union and gap engine: predicts each result and compares it.
module iuge_checker
    import iuge_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_request i_req,
    input  logic     i_valid,
    input  t_result  i_res,
    output int       o_error_count,
    output int       o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 100;

    typedef t_pair pair_list_t[$];

    pair_list_t stored_pairs;
    t_result    awaited_results[$];
    int         error_count  = 0;
    int         awaited_size = 0;

    assign o_error_count = error_count;
    assign o_awaited     = awaited_size;

    // Printing stops after a hundred lines so that a broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] result check: %s", $time, what);
        end
        error_count++;
    endtask

    // Returns the list with the pair placed after every pair that does not sort after it.
    function automatic pair_list_t sorted_with(input pair_list_t list, input t_pair p);
        pair_list_t merged;
        bit         placed;
        placed = 1'b0;
        foreach (list[k]) begin
            if (!placed && (p.start < list[k].start ||
                            (p.start == list[k].start && p.stop < list[k].stop))) begin
                merged.push_back(p);
                placed = 1'b1;
            end
            merged.push_back(list[k]);
        end
        if (!placed) begin
            merged.push_back(p);
        end
        return merged;
    endfunction

    task automatic queue_ack(input logic full, input int count);
        t_result e;
        e             = '0;
        e.kind        = KIND_ACK;
        e.status      = full;
        e.entry_count = OCNT_W'(count);
        e.last        = 1'b1;
        awaited_results.push_back(e);
    endtask

    // Each pair becomes an entry carrying the running length; a summary closes the request.
    task automatic queue_pairs(input pair_list_t list);
        t_result           e;
        logic [TIME_W-1:0] running;
        running = '0;
        foreach (list[k]) begin
            running        = running + (list[k].stop - list[k].start);
            e              = '0;
            e.kind         = KIND_ENTRY;
            e.out_start    = list[k].start;
            e.out_stop     = list[k].stop;
            e.total_length = running;
            e.entry_count  = OCNT_W'(k + 1);
            awaited_results.push_back(e);
        end
        e              = '0;
        e.kind         = KIND_SUMMARY;
        e.total_length = running;
        e.entry_count  = OCNT_W'(list.size());
        e.last         = 1'b1;
        awaited_results.push_back(e);
    endtask

    task automatic apply_request(input t_request r);
        t_pair             p;
        pair_list_t        gaps;
        logic [TIME_W-1:0] cursor;
        int                i;
        case (r.command)
            CMD_INSERT: begin
                if (stored_pairs.size() >= LIST_DEPTH) begin
                    queue_ack(1'b1, stored_pairs.size());
                end else begin
                    p            = '{r.start_time, r.stop_time};
                    stored_pairs = sorted_with(stored_pairs, p);
                    queue_ack(1'b0, stored_pairs.size());
                end
            end
            CMD_MERGE: begin
                i = 1;
                while (i < stored_pairs.size()) begin
                    if (stored_pairs[i-1].stop > stored_pairs[i].start) begin
                        p = stored_pairs[i-1];
                        if (p.stop < stored_pairs[i].stop) begin
                            p.stop = stored_pairs[i].stop;
                        end
                        stored_pairs[i-1] = p;
                        stored_pairs.delete(i);
                    end else begin
                        i++;
                    end
                end
                i = 0;
                while (i < stored_pairs.size()) begin
                    if (stored_pairs[i].start == stored_pairs[i].stop) begin
                        stored_pairs.delete(i);
                    end else begin
                        i++;
                    end
                end
                queue_pairs(stored_pairs);
            end
            CMD_GAPS: begin
                cursor = r.start_time;
                i      = 0;
                while (cursor < r.stop_time && i < stored_pairs.size()) begin
                    p      = '{cursor, stored_pairs[i].start};
                    gaps   = sorted_with(gaps, p);
                    cursor = stored_pairs[i].stop;
                    i++;
                end
                if (cursor < r.stop_time) begin
                    p    = '{cursor, r.stop_time};
                    gaps = sorted_with(gaps, p);
                end
                queue_pairs(gaps);
            end
            default: begin
                stored_pairs.delete();
                queue_ack(1'b0, 0);
            end
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected: kind %0d start %0h stop %0h",
                                      got.kind, got.out_start, got.out_stop));
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
        end
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
        end
        if (got.out_start !== want.out_start) begin
            report_mismatch($sformatf("out_start: expected %0h, got %0h",
                                      want.out_start, got.out_start));
        end
        if (got.out_stop !== want.out_stop) begin
            report_mismatch($sformatf("out_stop: expected %0h, got %0h",
                                      want.out_stop, got.out_stop));
        end
        if (got.total_length !== want.total_length) begin
            report_mismatch($sformatf("total_length: expected %0h, got %0h",
                                      want.total_length, got.total_length));
        end
        if (got.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                      want.entry_count, got.entry_count));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last: expected %0d, got %0d", want.last, got.last));
        end
    endtask

    // A result is checked before a request taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_pairs.delete();
            awaited_results.delete();
        end else begin
            if (i_valid) begin
                check_result(i_res);
            end
            if (i_start && !i_busy) begin
                apply_request(i_req);
            end
        end
        awaited_size = awaited_results.size();
    end

endmodule

### bench/tb_top.sv
// Top of the interval union and gap engine testbench: clock, reset, requests and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iuge_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 150;
    // The final stretch of requests is sent back to back, with no idling.
    localparam int QUIET_ITEMS    = 30;
    // A gap query over a full list whose gaps all need reordering issues nothing until
    // its gaps are sorted; the limit leaves a wide margin over that silence.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    t_request req;
    logic     busy;
    logic     o_valid;
    t_result  res;
    int       error_count;
    int       awaited;

    int                idle_cycles = 0;
    int                items_left  = 0;
    bit                idling_on   = 1'b1;
    logic [TIME_W-1:0] cluster_base = '0;

    interval_union_and_gap_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (res)
    );

    iuge_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (req),
        .i_valid       (o_valid),
        .i_res         (res),
        .o_error_count (error_count),
        .o_awaited     (awaited)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The watchdog counts cycles in which neither a request nor a result is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Times are drawn mostly from a narrow cluster so that intervals overlap and touch;
    // the rest come from the whole range or just below its top, where lengths wrap.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return TIME_MAX - $urandom_range(0, 300);
            default: return cluster_base + $urandom_range(0, 400);
        endcase
    endfunction

    // Stops are usually just after the start, sometimes equal to it, before it,
    // or anywhere at all.
    function automatic logic [TIME_W-1:0] pick_stop(input logic [TIME_W-1:0] from);
        case ($urandom_range(0, 7))
            0:       return from;
            1:       return from - $urandom_range(1, 40);
            2:       return $urandom;
            default: return from + $urandom_range(1, 120);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_window_end(input logic [TIME_W-1:0] from);
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return TIME_MAX;
            default: return from + $urandom_range(0, 800);
        endcase
    endfunction

    // Sends one request and returns at the edge that takes it. An idle burst may
    // come first; start is only ever changed at a falling edge, once per edge.
    task automatic issue(input t_command cmd, input logic [TIME_W-1:0] t1,
                         input logic [TIME_W-1:0] t2);
        if (idling_on && items_left > QUIET_ITEMS && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start          <= 1'b1;
        req.command    <= cmd;
        req.start_time <= t1;
        req.stop_time  <= t2;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (items_left > 0) begin
            items_left--;
        end
    endtask

    // Holds back the next request until every predicted result has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic issue_window(input t_command cmd);
        logic [TIME_W-1:0] w_start;
        w_start = pick_time();
        issue(cmd, w_start, pick_window_end(w_start));
    endtask

    // One episode fills the list with random intervals, mixes in queries and the odd
    // fully random request, then queries and perhaps clears. The first episode tries
    // to overfill the list so that full-list inserts can be exercised.
    task automatic run_episode(input bit overfill);
        int                fill;
        logic [TIME_W-1:0] t;
        cluster_base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
        idling_on    = ($urandom_range(0, 2) != 0);
        if (overfill) begin
            fill = LIST_DEPTH + 2;
        end else if ($urandom_range(0, 4) == 0) begin
            fill = $urandom_range(20, LIST_DEPTH + 3);
        end else begin
            fill = $urandom_range(1, 10);
        end
        for (int n = 0; n < fill && items_left > 0; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                issue(t_command'($urandom_range(0, 3)), $urandom, $urandom);
            end else begin
                t = pick_time();
                issue(CMD_INSERT, t, pick_stop(t));
            end
            if ($urandom_range(0, 7) == 0) begin
                issue_window(CMD_GAPS);
            end
        end
        repeat ($urandom_range(1, 3)) begin
            issue_window(($urandom_range(0, 1) == 0) ? CMD_GAPS : CMD_MERGE);
        end
        if ($urandom_range(0, 1) == 0) begin
            issue(CMD_CLEAR, $urandom, $urandom);
        end
        // Pauses only outside the final back-to-back stretch.
        if (items_left > QUIET_ITEMS && $urandom_range(0, 2) == 0) begin
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        req     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty-list merge and gaps, an empty window, reversed,
        // duplicate and zero-length intervals, both ends of the time range, gaps that
        // come out of order and need sorting, and a repeated merge.
        issue(CMD_CLEAR, TIME_MAX, TIME_MAX);
        issue(CMD_MERGE, '0, '0);
        issue(CMD_GAPS, 32'd10, 32'd20);
        issue(CMD_GAPS, 32'd20, 32'd10);
        issue(CMD_INSERT, 32'd100, 32'd50);
        issue(CMD_INSERT, 32'd5, 32'd10);
        issue(CMD_INSERT, 32'd5, 32'd10);
        issue(CMD_INSERT, 32'd7, 32'd7);
        issue(CMD_INSERT, '0, '0);
        issue(CMD_INSERT, TIME_MAX, TIME_MAX);
        issue(CMD_INSERT, '0, TIME_MAX);
        issue(CMD_INSERT, 32'd3, 32'd8);
        issue(CMD_INSERT, 32'd200, 32'd300);
        issue(CMD_GAPS, '0, TIME_MAX);
        issue(CMD_GAPS, 32'd1, 32'd250);
        issue(CMD_MERGE, '0, '0);
        issue(CMD_GAPS, '0, 32'd1000);
        issue(CMD_MERGE, TIME_MAX, TIME_MAX);
        issue(CMD_CLEAR, '0, '0);
        issue(CMD_INSERT, 32'd50, 32'd60);
        issue(CMD_INSERT, 32'd10, 32'd20);
        issue(CMD_GAPS, '0, 32'd100);
        issue(CMD_GAPS, 32'd15, 32'd55);
        issue(CMD_MERGE, '0, '0);
        issue(CMD_CLEAR, '0, '0);
        wait_drained();

        items_left = RANDOM_ITEMS;
        run_episode(1'b1);
        while (items_left > 0) begin
            run_episode(1'b0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0 && awaited == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
